// File: rtl/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg: shared types and constants for the multi-shape LFO
// Phase and table sizes, shape and register codes, quarter-wave sine table.
// ----------------------------------------------------------------------------
package msl_pkg;

    // Phase accumulator width and quarter-wave table depth (power of two)
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);

    localparam logic [SINE_ADDR_BITS:0] SINE_TOP = (SINE_ADDR_BITS + 1)'(SINE_TABLE_DEPTH);

    // Field widths fixed by the interface
    localparam int INC_BITS   = 31;
    localparam int SHAPE_BITS = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INC = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHAPE     = 8'd1;

    // Reset value of the phase increment (1 Hz, 44.1 kHz, 64-sample blocks)
    localparam logic [INC_BITS-1:0] INC_RESET = 31'd6233059;

    // Wave shape codes; codes above SHAPE_RANDOM leave the output unchanged
    typedef enum logic [SHAPE_BITS-1:0] {
        SHAPE_SINE     = 3'd0,
        SHAPE_TRIANGLE = 3'd1,
        SHAPE_SAW      = 3'd2,
        SHAPE_SQUARE   = 3'd3,
        SHAPE_RANDOM   = 3'd4
    } t_shape;

    // Quarter-wave sine table, Q1.15 magnitude, DEPTH+1 entries
    typedef logic [SINE_TABLE_DEPTH:0][14:0] t_sine_rom;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Taylor series to x^11 in Q30, evaluated at elaboration
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        scaled;
        logic signed [63:0] sum;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 110;
            sum  = sum - $signed(term);
            if (sum < 0) begin
                sum = 0;
            end
            scaled = (64'(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
            if (scaled > 64'd32767) begin
                scaled = 64'd32767;
            end
            rom[i] = scaled[14:0];
        end
        rom[SINE_TABLE_DEPTH] = 15'h7FFF;
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// File: rtl/multi_shape_lfo.sv
// ----------------------------------------------------------------------------
// multi_shape_lfo: block-rate low-frequency oscillator
// Phase accumulator with sine, triangle, saw, square and sample-and-hold
// outputs in signed Q1.15.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  input    | i_valid / o_ready          | i_random_sample
//  output   | o_valid / i_ready          | o_lfo_value, o_cycle_wrapped
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One tick per cycle sustained unless the output stalls; o_valid is registered.
//  The phase add closes in the accept cycle; the shape stage and the output
//  register follow, so the phase loop sets the one-tick-per-cycle figure.
//  A stalled output holds its transaction; the shape stage keeps one more
//  tick, then o_ready drops until the output moves.
//  Sync active-low reset clears phase, held value, valids; loads config defaults.
//
module multi_shape_lfo (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Tick input
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [msl_pkg::SAMPLE_BITS-1:0] i_random_sample,
    // Result output
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [msl_pkg::SAMPLE_BITS-1:0] o_lfo_value,
    output logic                                 o_cycle_wrapped,
    // Configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [msl_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [msl_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import msl_pkg::*;

    // Configuration registers
    logic [INC_BITS-1:0]   r_inc;
    logic [SHAPE_BITS-1:0] r_shape;

    // Phase accumulator
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS:0]   n_sum;

    // Shape stage
    logic                         r_s1_valid;
    logic [PHASE_BITS-1:0]        r_s1_phase;
    logic                         r_s1_wrap;
    logic signed [SAMPLE_BITS-1:0] r_s1_rnd;

    // Output register; r_lfo_value doubles as the held value
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_lfo_value;
    logic                          r_cycle_wrapped;

    logic in_fire;
    logic out_move;
    logic s1_move;

    // Pipeline advance
    assign out_move = !r_out_valid || i_ready;
    assign s1_move  = !r_s1_valid || out_move;
    assign o_ready  = s1_move;
    assign in_fire  = i_valid && o_ready;

    assign o_cfg_ready = 1'b1;

    // Configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc   <= INC_RESET;
            r_shape <= SHAPE_SINE;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PHASE_INC) begin
                r_inc <= i_cfg_data[INC_BITS-1:0];
            end else if (i_cfg_index == CFG_SHAPE) begin
                r_shape <= i_cfg_data[SHAPE_BITS-1:0];
            end
        end
    end

    // Phase add; increment taken modulo one cycle
    assign n_sum = {1'b0, r_phase} + {1'b0, PHASE_BITS'(r_inc)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_s1_valid <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= in_fire;
            if (in_fire) begin
                r_phase <= n_sum[PHASE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && in_fire) begin
            r_s1_phase <= n_sum[PHASE_BITS-1:0];
            r_s1_wrap  <= n_sum[PHASE_BITS];
            r_s1_rnd   <= i_random_sample;
        end
    end

    // Shape stage
    logic [15:0]                   p16;
    logic [1:0]                    quad;
    logic [SINE_ADDR_BITS-1:0]     sine_k;
    logic [SINE_ADDR_BITS:0]       sine_idx;
    logic [14:0]                   sine_mag;
    logic signed [SAMPLE_BITS-1:0] sine_val;
    logic signed [17:0]            tri_wide;
    logic signed [SAMPLE_BITS-1:0] tri_val;
    logic signed [SAMPLE_BITS-1:0] n_value;

    assign p16    = r_s1_phase[PHASE_BITS-1 -: 16];
    assign quad   = r_s1_phase[PHASE_BITS-1 -: 2];
    assign sine_k = r_s1_phase[PHASE_BITS-3 -: SINE_ADDR_BITS];

    // Quarter-wave lookup with mirror and sign by quadrant
    always_comb begin
        sine_idx = quad[0] ? (SINE_TOP - {1'b0, sine_k}) : {1'b0, sine_k};
        sine_mag = SINE_ROM[sine_idx];
        sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
    end

    // Triangle, peak of +1 saturated
    always_comb begin
        if (!p16[15]) begin
            tri_wide = $signed({2'b00, p16[14:0], 1'b0}) - 18'sd32768;
        end else begin
            tri_wide = 18'sd98304 - $signed({1'b0, p16, 1'b0});
        end
        if (tri_wide > 18'sd32767) begin
            tri_val = 16'sh7FFF;
        end else begin
            tri_val = tri_wide[15:0];
        end
    end

    always_comb begin
        unique case (r_shape)
            SHAPE_SINE:     n_value = sine_val;
            SHAPE_TRIANGLE: n_value = tri_val;
            SHAPE_SAW:      n_value = $signed({~p16[15], p16[14:0]});
            SHAPE_SQUARE:   n_value = p16[15] ? 16'sh8000 : 16'sh7FFF;
            SHAPE_RANDOM:   n_value = r_s1_wrap ? r_s1_rnd : r_lfo_value;
            default:        n_value = r_lfo_value;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_lfo_value <= '0;
        end else if (out_move) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_lfo_value <= n_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move && r_s1_valid) begin
            r_cycle_wrapped <= r_s1_wrap;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_lfo_value     = r_lfo_value;
    assign o_cycle_wrapped = r_cycle_wrapped;

endmodule

// File: rtl/msl_checker.sv
// ----------------------------------------------------------------------------
// msl_checker: port-level checks for multi_shape_lfo
// Tracks ticks in flight and the written shape; bound to the top level.
// ----------------------------------------------------------------------------
module msl_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic signed [msl_pkg::SAMPLE_BITS-1:0] o_lfo_value,
    input logic                                 o_cycle_wrapped,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready,
    input logic [msl_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input logic [msl_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import msl_pkg::*;

    logic [1:0]            r_pending;
    logic [SHAPE_BITS-1:0] r_shape;
    logic                  in_fire;
    logic                  out_fire;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;

    // Ticks accepted whose result is not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_fire && !out_fire) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_fire && !in_fire) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    // Shape as last written on the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_SINE;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_SHAPE) begin
            r_shape <= i_cfg_data[SHAPE_BITS-1:0];
        end
    end

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_lfo_value) && $stable(o_cycle_wrapped))
        else $error("stalled result changed");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // No result without a tick in flight, never more than two in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd3) && ((r_pending == 2'd0) -> !o_valid))
        else $error("result count does not match accepted ticks");

    // Square shape gives only the two rails
    a_square_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_shape == SHAPE_SQUARE |->
            o_lfo_value == 16'sh7FFF || o_lfo_value == 16'sh8000)
        else $error("square output off the rails");

endmodule

bind multi_shape_lfo msl_checker u_msl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_lfo_value     (o_lfo_value),
    .o_cycle_wrapped (o_cycle_wrapped),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_cfg_index     (i_cfg_index),
    .i_cfg_data      (i_cfg_data)
);

// File: test/tb_multi_shape_lfo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_shape_lfo: self-checking testbench for the multi-shape LFO
// Sends ticks and register writes over valid/ready channels, predicts every
// result with an independent phase and shape model, and compares each field
// of each output transaction in order. Directed corners come first, then
// randomized segments under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_multi_shape_lfo;
    import msl_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int REPORT_MAX  = 25;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_TOP   = 8'hFF;
    localparam logic [SHAPE_BITS-1:0]     SHAPE_UNUSED_TOP = 3'd7;
    localparam logic [INC_BITS-1:0]       INC_QUARTER      = 31'h4000_0000;
    localparam logic [INC_BITS-1:0]       INC_MAX          = 31'h7FFF_FFFF;

    // pi/2 in Q30, used to build the quarter-wave table
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

    // DUT ports
    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_valid         = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_random_sample = '0;
    logic                          o_valid;
    logic                          i_ready         = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_lfo_value;
    logic                          o_cycle_wrapped;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data      = '0;

    // Oscillator model state and register copies
    logic [PHASE_BITS-1:0]         model_phase;
    logic signed [SAMPLE_BITS-1:0] model_held;
    logic [INC_BITS-1:0]           model_inc;
    logic [SHAPE_BITS-1:0]         model_shape;
    int                            quarter_sine [0:SINE_TABLE_DEPTH];

    // Results still owed by the DUT, oldest first
    logic signed [SAMPLE_BITS-1:0] due_value [$];
    logic                          due_wrap  [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_errors       = 0;
    int n_ticks        = 0;
    int n_results      = 0;
    int n_cfg_writes   = 0;

    multi_shape_lfo i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_random_sample (i_random_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_lfo_value     (o_lfo_value),
        .o_cycle_wrapped (o_cycle_wrapped),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // One table entry: sin(pi/2 * idx / DEPTH) by odd series to x^11, Q1.15
    function automatic int sine_entry(int idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned scaled;
        longint          acc;
        x    = (QUARTER_TURN_Q30 * longint'(idx)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        scaled = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
        if (scaled > 32767) begin
            scaled = 32767;
        end
        return int'(scaled);
    endfunction

    // Advance the oscillator by one tick and form its output
    function automatic void step_lfo(input logic signed [SAMPLE_BITS-1:0] rnd_in,
                                     output logic signed [SAMPLE_BITS-1:0] value,
                                     output logic wrap);
        logic [PHASE_BITS:0] sum;
        logic [15:0]         p16;
        int                  v;
        int                  idx;
        sum         = {1'b0, model_phase} + {{(PHASE_BITS - INC_BITS + 1){1'b0}}, model_inc};
        wrap        = sum[PHASE_BITS];
        model_phase = sum[PHASE_BITS-1:0];
        p16         = model_phase[PHASE_BITS-1 -: 16];
        v           = model_held;
        case (model_shape)
            SHAPE_SINE: begin
                idx = int'(model_phase[PHASE_BITS-3 -: SINE_ADDR_BITS]);
                if (model_phase[PHASE_BITS-2]) begin
                    idx = SINE_TABLE_DEPTH - idx;
                end
                v = quarter_sine[idx];
                if (model_phase[PHASE_BITS-1]) begin
                    v = -v;
                end
            end
            SHAPE_TRIANGLE: begin
                if (!p16[15]) begin
                    v = 2 * int'(p16) - 32768;
                end else begin
                    v = 98304 - 2 * int'(p16);
                end
                // peak of +1 saturates
                if (v > 32767) begin
                    v = 32767;
                end
            end
            SHAPE_SAW: begin
                v = int'(p16) - 32768;
            end
            SHAPE_SQUARE: begin
                v = p16[15] ? -32768 : 32767;
            end
            SHAPE_RANDOM: begin
                if (wrap) begin
                    v = rnd_in;
                end
            end
            default: begin
                // unused codes hold the last value
            end
        endcase
        model_held = SAMPLE_BITS'(v);
        value      = model_held;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < REPORT_MAX) begin
            $display("MISMATCH %s at result %0d: got %0d, want %0d", what, n_results, got, want);
        end
        n_errors++;
    endtask

    // Result checker: every output transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (due_value.size() == 0) begin
                report_mismatch("unexpected result", o_lfo_value, 0);
            end else begin
                if (o_lfo_value !== due_value[0]) begin
                    report_mismatch("lfo_value", o_lfo_value, due_value[0]);
                end
                if (o_cycle_wrapped !== due_wrap[0]) begin
                    report_mismatch("cycle_wrapped", o_cycle_wrapped, due_wrap[0]);
                end
                void'(due_value.pop_front());
                void'(due_wrap.pop_front());
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // One tick transaction, with a random idle gap ahead of it
    task automatic send_tick(input logic signed [SAMPLE_BITS-1:0] rnd_in);
        int                            gap;
        logic signed [SAMPLE_BITS-1:0] want_value;
        logic                          want_wrap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_random_sample <= rnd_in;
        do @(posedge i_clk); while (!o_ready);
        step_lfo(rnd_in, want_value, want_wrap);
        due_value.push_back(want_value);
        due_wrap.push_back(want_wrap);
        n_ticks++;
    endtask

    // Stop sending and wait until every owed result has arrived
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_value.size() != 0);
    endtask

    // One register write transaction; valid drops after the last of a group
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data, input bit last_one);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_PHASE_INC) begin
            model_inc = data[INC_BITS-1:0];
        end else if (index == CFG_SHAPE) begin
            model_shape = data[SHAPE_BITS-1:0];
        end
        n_cfg_writes++;
        if (last_one) begin
            i_cfg_valid <= 1'b0;
        end
    endtask

    // Both registers, with random junk in the bits above each width
    task automatic set_lfo(input logic [INC_BITS-1:0] inc, input logic [SHAPE_BITS-1:0] shape);
        cfg_write(CFG_PHASE_INC, {1'($urandom_range(0, 1)), inc}, 1'b0);
        cfg_write(CFG_SHAPE, {29'($urandom), shape}, 1'b1);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Reset values: default increment, sine
    task automatic test_reset_defaults();
        send_tick(16'sh1234);
        send_tick(-16'sh1234);
        drain();
    endtask

    // Quarter-cycle steps land on quadrant edges, triangle peak, square edge
    task automatic test_wave_corners();
        set_lfo(INC_QUARTER - model_phase[PHASE_BITS-3:0], SHAPE_SINE);
        send_tick(16'sh0000);
        drain();
        set_lfo(INC_QUARTER, SHAPE_SINE);
        repeat (4) send_tick(pick_sample());
        drain();
        set_lfo(INC_QUARTER, SHAPE_TRIANGLE);
        repeat (4) send_tick(pick_sample());
        drain();
        set_lfo(INC_QUARTER, SHAPE_SAW);
        repeat (2) send_tick(pick_sample());
        drain();
        set_lfo(INC_QUARTER, SHAPE_SQUARE);
        repeat (2) send_tick(pick_sample());
        drain();
    endtask

    // Sample-and-hold: the first tick keeps the square value, wraps latch input
    task automatic test_random_hold();
        cfg_write(CFG_PHASE_INC, 32'hFFFF_FFFF, 1'b0);
        cfg_write(CFG_SHAPE, {29'd0, SHAPE_RANDOM}, 1'b1);
        send_tick(16'sh8000);
        send_tick(16'sh7FFF);
        send_tick(16'sh0000);
        send_tick(16'sh5A5A);
        drain();
    endtask

    // Unused shape codes, unknown register indexes, zero increment
    task automatic test_unused_and_zero();
        for (int code = int'(SHAPE_RANDOM) + 1; code <= int'(SHAPE_UNUSED_TOP); code++) begin
            cfg_write(CFG_SHAPE, {{(CFG_DATA_BITS - SHAPE_BITS){1'b1}}, SHAPE_BITS'(code)}, 1'b1);
            send_tick(pick_sample());
            drain();
        end
        cfg_write(CFG_UNUSED_TOP, 32'hFFFF_FFFF, 1'b0);
        cfg_write(CFG_SHAPE + 8'd1, 32'h0000_0000, 1'b0);
        cfg_write(CFG_PHASE_INC, 32'h8000_0000, 1'b0);
        cfg_write(CFG_SHAPE, {29'd0, SHAPE_SAW}, 1'b1);
        send_tick(pick_sample());
        send_tick(pick_sample());
        drain();
    endtask

    // Random segments, each under a fresh register setting
    task automatic test_random_segments(input int idle_pct, input int stall_pct,
                                        input int n_segments);
        logic [INC_BITS-1:0]   inc;
        logic [SHAPE_BITS-1:0] shape;
        int                    pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_segments) begin
            case ($urandom_range(0, 7))
                0:       inc = '0;
                1:       inc = INC_MAX;
                2:       inc = INC_RESET;
                3:       inc = INC_QUARTER;
                4:       inc = INC_BITS'($urandom_range(1, 1 << 16));
                default: inc = INC_BITS'($urandom);
            endcase
            pick  = $urandom_range(0, 9);
            shape = (pick < 8) ? SHAPE_BITS'(pick) : SHAPE_RANDOM;
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(CFG_INDEX_BITS'($urandom_range(2, 255)), $urandom, 1'b0);
            end
            set_lfo(inc, shape);
            repeat ($urandom_range(20, 60)) send_tick(pick_sample());
            drain();
        end
    endtask

    // Test sequence
    initial begin
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            quarter_sine[i] = sine_entry(i);
        end
        quarter_sine[SINE_TABLE_DEPTH] = 32767;
        model_phase = '0;
        model_held  = '0;
        model_inc   = INC_RESET;
        model_shape = SHAPE_SINE;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_wave_corners();
        test_random_hold();
        test_unused_and_zero();
        test_random_segments(0, 0, 8);
        test_random_segments(60, 0, 8);
        test_random_segments(0, 60, 8);
        test_random_segments(34, 34, 8);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d ticks, %0d results, %0d register writes", n_ticks, n_results,
                 n_cfg_writes);
        $display("all five shapes, unused codes, zero and full-range steps, four flow mixes");
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
